// File: sv/sphere_wireframe_line_indices_core_assert.svh
// Assertion macros shared by the sphere wireframe line index generator.
`ifndef SPHERE_WIREFRAME_LINE_INDICES_CORE_ASSERT_SVH
`define SPHERE_WIREFRAME_LINE_INDICES_CORE_ASSERT_SVH

// The condition on the left implies the one on the right in the same cycle.
`define SWLI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The condition on the left implies the one on the right in the next cycle.
`define SWLI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/swli_pkg.sv
// Types and constants of the sphere wireframe line index generator.
`default_nettype none

package swli_pkg;

	localparam int CFG_W    = 7;
	localparam int CFG_IDXW = 2;
	localparam int VERT_W   = 12;
	localparam int LINE_W   = 13;

	typedef logic [CFG_W-1:0]    cfg_data_t;
	typedef logic [CFG_IDXW-1:0] cfg_index_t;
	typedef logic [VERT_W-1:0]   vert_t;
	typedef logic [LINE_W-1:0]   line_t;
	typedef logic [1:0]          phase_t;

	localparam cfg_index_t REG_LATITUDE  = 2'd0;
	localparam cfg_index_t REG_LONGITUDE = 2'd1;

	localparam cfg_data_t LATITUDE_RESET  = 7'd8;
	localparam cfg_data_t LONGITUDE_RESET = 7'd8;

	localparam phase_t PH_RING  = 2'd0;
	localparam phase_t PH_NORTH = 2'd1;
	localparam phase_t PH_MERID = 2'd2;
	localparam phase_t PH_SOUTH = 2'd3;

endpackage

`default_nettype wire

// File: sv/sphere_wireframe_line_indices_core.sv
// Sphere wireframe line index generator: one edge of the UV-sphere edge list per transfer,
// in the order ring edges, north spokes, meridian segments, south spokes. Each accepted
// input item produces one result, registered in the output register; a new item is taken
// every cycle while the output register is empty or being drained, so the rate is one line
// per clock. The step logic is a few counter adds and compares plus one narrow multiply for
// the south ring base. A write to the latitude or longitude register sets it (out-of-range
// values are saturated) and returns the generator to line 0; write only while idle.
`default_nettype none

module sphere_wireframe_line_indices_core #(
	parameter int MAX_LATITUDE_STEPS  = 64,
	parameter int MAX_LONGITUDE_STEPS = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  swli_pkg::cfg_index_t cfg_index,
	input  wire  swli_pkg::cfg_data_t  cfg_data,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire                     restart,
	output logic                    out_valid,
	input  wire                     out_ready,
	output swli_pkg::vert_t         endpoint_a,
	output swli_pkg::vert_t         endpoint_b,
	output swli_pkg::line_t         line_number,
	output logic                    last_line
);

	import swli_pkg::*;

	localparam int MAXS = (MAX_LATITUDE_STEPS > MAX_LONGITUDE_STEPS) ?
		MAX_LATITUDE_STEPS : MAX_LONGITUDE_STEPS;
	localparam int CW   = $clog2(MAXS + 1);
	localparam int EW   = (CW > CFG_W) ? CW : CFG_W;
	localparam int PW   = 2 * CW;

	typedef logic [CW-1:0] cnt_t;

	cfg_data_t lat_q, lon_q;
	phase_t    phase_q;
	cnt_t      outer_q, inner_q;
	vert_t     rb_q;
	line_t     count_q;

	logic      in_xfer, cfg_xfer, cfg_hit;

	// Saturated register values.
	logic [EW-1:0] lat_ext, lon_ext;
	cnt_t          lat_e, lon_e, lat_m1, lat_m2;
	logic [PW-1:0] prod;
	vert_t         south_base;

	// Step view of the state, with restart applied first.
	phase_t ph_c;
	cnt_t   outer_c, inner_c, outer_p1, inner_p1;
	vert_t  rb_c;
	line_t  count_c;

	phase_t ph_n;
	cnt_t   outer_n, inner_n;
	vert_t  rb_n;
	vert_t  a_n, b_n;
	logic   last_n;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_xfer && (cfg_index == REG_LATITUDE || cfg_index == REG_LONGITUDE);

	always_comb begin
		lat_ext = EW'(lat_q);
		lon_ext = EW'(lon_q);
		if (lat_ext < EW'(2)) begin
			lat_e = CW'(2);
		end else if (lat_ext > EW'(MAX_LATITUDE_STEPS)) begin
			lat_e = CW'(MAX_LATITUDE_STEPS);
		end else begin
			lat_e = CW'(lat_ext);
		end
		if (lon_ext < EW'(4)) begin
			lon_e = CW'(4);
		end else if (lon_ext > EW'(MAX_LONGITUDE_STEPS)) begin
			lon_e = CW'(MAX_LONGITUDE_STEPS);
		end else begin
			lon_e = CW'(lon_ext);
		end
		lat_m1     = lat_e - CW'(1);
		lat_m2     = lat_e - CW'(2);
		prod       = PW'(lat_m2) * PW'(lon_e);
		south_base = VERT_W'(prod);
	end

	always_comb begin
		if (restart) begin
			ph_c    = PH_RING;
			outer_c = '0;
			inner_c = '0;
			rb_c    = '0;
			count_c = '0;
		end else begin
			ph_c    = phase_q;
			outer_c = outer_q;
			inner_c = inner_q;
			rb_c    = rb_q;
			count_c = count_q;
		end
		outer_p1 = outer_c + CW'(1);
		inner_p1 = inner_c + CW'(1);

		ph_n    = ph_c;
		outer_n = outer_c;
		inner_n = inner_p1;
		rb_n    = rb_c;
		last_n  = 1'b0;
		a_n     = '0;
		b_n     = '0;

		unique case (ph_c)
			PH_RING: begin
				if (inner_p1 < lon_e) begin
					a_n = rb_c + VERT_W'(inner_p1);
					b_n = rb_c + VERT_W'(inner_p1) + VERT_W'(1);
				end else begin
					a_n = rb_c + VERT_W'(1);
					b_n = rb_c + VERT_W'(lon_e);
				end
				if (inner_p1 >= lon_e) begin
					inner_n = '0;
					outer_n = outer_p1;
					rb_n    = rb_c + VERT_W'(lon_e);
					if (outer_p1 >= lat_m1) begin
						ph_n    = PH_NORTH;
						outer_n = '0;
						rb_n    = '0;
					end
				end
			end
			PH_NORTH: begin
				a_n = '0;
				b_n = VERT_W'(inner_p1);
				if (inner_p1 >= lon_e) begin
					inner_n = '0;
					outer_n = '0;
					if (lat_e > CW'(2)) begin
						ph_n = PH_MERID;
						rb_n = '0;
					end else begin
						ph_n = PH_SOUTH;
						rb_n = south_base;
					end
				end
			end
			PH_MERID: begin
				a_n  = rb_c + VERT_W'(outer_p1);
				b_n  = rb_c + VERT_W'(lon_e) + VERT_W'(outer_p1);
				rb_n = rb_c + VERT_W'(lon_e);
				if (inner_p1 >= lat_m2) begin
					inner_n = '0;
					rb_n    = '0;
					outer_n = outer_p1;
					if (outer_p1 >= lon_e) begin
						ph_n    = PH_SOUTH;
						outer_n = '0;
						rb_n    = south_base;
					end
				end
			end
			PH_SOUTH: begin
				a_n = rb_c + VERT_W'(inner_p1);
				b_n = south_base + VERT_W'(lon_e) + VERT_W'(1);
				if (inner_p1 >= lon_e) begin
					last_n  = 1'b1;
					ph_n    = PH_RING;
					outer_n = '0;
					inner_n = '0;
					rb_n    = '0;
				end
			end
			default: begin
				ph_n = PH_RING;
			end
		endcase
	end

	// Configuration registers and generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q   <= LATITUDE_RESET;
			lon_q   <= LONGITUDE_RESET;
			phase_q <= PH_RING;
			outer_q <= '0;
			inner_q <= '0;
			rb_q    <= '0;
			count_q <= '0;
		end else begin
			if (cfg_xfer && cfg_index == REG_LATITUDE) begin
				lat_q <= cfg_data;
			end
			if (cfg_xfer && cfg_index == REG_LONGITUDE) begin
				lon_q <= cfg_data;
			end
			if (cfg_hit) begin
				phase_q <= PH_RING;
				outer_q <= '0;
				inner_q <= '0;
				rb_q    <= '0;
				count_q <= '0;
			end else if (in_xfer) begin
				phase_q <= ph_n;
				outer_q <= outer_n;
				inner_q <= inner_n;
				rb_q    <= rb_n;
				count_q <= last_n ? '0 : count_c + LINE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_xfer) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			endpoint_a  <= a_n;
			endpoint_b  <= b_n;
			line_number <= count_c;
			last_line   <= last_n;
		end
	end

`include "sphere_wireframe_line_indices_core_assert.svh"

	`SWLI_ASSERT_NEXT(a_restart_line0, in_valid && in_ready && restart, out_valid && line_number == '0)
	`SWLI_ASSERT_NOW(a_last_wraps, out_valid && last_line, count_q == '0 && phase_q == PH_RING)
	`SWLI_ASSERT_NOW(a_empty_takes, !out_valid, in_ready)
	`SWLI_ASSERT_NOW(a_north_clear, phase_q == PH_NORTH, outer_q == '0 && rb_q == '0)

endmodule

`default_nettype wire
